[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is masked while reset is held
`define TBC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also covers the reset cycles
`define TBC_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/tbc_pkg.sv]
// ----------------------------------------------------------------------------
// tbc_pkg
// types and constants of the tile border compositor
// ----------------------------------------------------------------------------
`default_nettype none

package tbc_pkg;

  localparam int FRAME_WIDTH  = 256;
  localparam int FRAME_HEIGHT = 224;
  localparam int GAME_WIDTH   = 160;
  localparam int GAME_HEIGHT  = 144;
  localparam int WIN_X        = 48;
  localparam int WIN_Y        = 40;

  localparam int STORE_DEPTH  = 10368;
  localparam int MAP_WORDS    = 1024;
  localparam int TILE_WORDS   = 2048;
  localparam int PAL_WORDS    = 64;
  localparam int QUEUE_DEPTH  = 4;
  localparam int OUT_DEPTH    = 8;

  // register indexes
  localparam logic CFG_DISPLAY_MODE  = 1'b0;
  localparam logic CFG_BORDER_LOADED = 1'b1;

  // address region of the palettes, bits 13..7
  localparam logic [6:0] PAL_REGION = 7'h50;

  localparam logic [15:0] FRAME_C0 = 16'((2)  | (3  << 5) | (10 << 10));
  localparam logic [15:0] FRAME_C1 = 16'((5)  | (8  << 5) | (19 << 10));
  localparam logic [15:0] FRAME_C2 = 16'((11) | (15 << 5) | (27 << 10));
  localparam logic [15:0] FRAME_C3 = 16'((25) | (23 << 5) | (11 << 10));

  typedef enum logic [1:0] {
    K_WRITE  = 2'd0,
    K_PASS   = 2'd1,
    K_DECODE = 2'd2
  } kind_t;

  typedef struct packed {
    logic display_mode;
    logic border_loaded;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [13:0] addr;
    logic [7:0]  data;
    logic [15:0] color;
    logic [7:0]  px;
    logic [7:0]  py;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qhead_t;

  function automatic logic [15:0] procedural_pixel(logic [7:0] x, logic [7:0] y);
    logic band;
    logic [15:0] c;
    band = x[3] ^ y[3];
    if (x < 8'd8 || x >= 8'(FRAME_WIDTH - 8) || y < 8'd8 || y >= 8'(FRAME_HEIGHT - 8))
      c = FRAME_C3;
    else if (x < 8'd40 || x >= 8'(FRAME_WIDTH - 40) || y < 8'd32 ||
             y >= 8'(FRAME_HEIGHT - 32))
      c = band ? FRAME_C2 : FRAME_C1;
    else
      c = band ? FRAME_C1 : FRAME_C0;
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tbc_ram.sv]
// ----------------------------------------------------------------------------
// tbc_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module tbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[hw/rtl/tbc_front.sv]
// ----------------------------------------------------------------------------
// tbc_front
// accepts items, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module tbc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tbc_pkg::cfg_t cfg,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire logic          in_command,
  input  wire logic [13:0]   in_load_address,
  input  wire logic [7:0]    in_load_data,
  input  wire logic [7:0]    in_pixel_x,
  input  wire logic [7:0]    in_pixel_y,
  input  wire logic [15:0]   in_game_pixel,
  output tbc_pkg::qhead_t    head,
  input  wire logic          head_pop
);

  localparam int PW = $clog2(tbc_pkg::QUEUE_DEPTH);

  tbc_pkg::qent_t ent;
  tbc_pkg::qent_t q_r [tbc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]    cnt_r, cnt_nxt;
  logic           in_win, push, pop;

  always_comb begin
    in_win = ({1'b0, in_pixel_x} >= 9'(tbc_pkg::WIN_X)) &&
             ({1'b0, in_pixel_x} <  9'(tbc_pkg::WIN_X + tbc_pkg::GAME_WIDTH)) &&
             ({1'b0, in_pixel_y} >= 9'(tbc_pkg::WIN_Y)) &&
             ({1'b0, in_pixel_y} <  9'(tbc_pkg::WIN_Y + tbc_pkg::GAME_HEIGHT));
    ent.addr  = in_load_address;
    ent.data  = in_load_data;
    ent.px    = in_pixel_x;
    ent.py    = in_pixel_y;
    ent.color = in_game_pixel;
    if (!in_command) begin
      ent.kind = tbc_pkg::K_WRITE;
    end else if (!cfg.display_mode || in_win) begin
      ent.kind = tbc_pkg::K_PASS;
    end else if (cfg.border_loaded) begin
      ent.kind = tbc_pkg::K_DECODE;
    end else begin
      ent.kind  = tbc_pkg::K_PASS;
      ent.color = tbc_pkg::procedural_pixel(in_pixel_x, in_pixel_y);
    end
  end

  assign in_full = (cnt_r == (PW+1)'(tbc_pkg::QUEUE_DEPTH));
  assign push    = in_push && !in_full;
  assign head    = {(cnt_r != '0), q_r[rp_r]};
  assign pop     = head_pop && head.valid;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= ent;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tbc_back.sv]
// ----------------------------------------------------------------------------
// tbc_back
// border decode pipeline over banked stores, with the result queue
// ----------------------------------------------------------------------------
`default_nettype none

module tbc_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tbc_pkg::qhead_t head,
  output logic                 head_pop,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output logic [15:0]          out_pixel_color
);

  localparam int OW = $clog2(tbc_pkg::OUT_DEPTH);

  typedef struct packed {
    logic           valid;
    tbc_pkg::qent_t ent;
  } stage_t;

  stage_t s1_r, s2_r, s3_r;
  logic [1:0]  s2_pal_r, s2_pal_nxt;
  logic [2:0]  s2_bit_r, s2_bit_nxt;

  logic [7:0]  map_q [2];
  logic [7:0]  tile_q [4];
  logic [7:0]  pal_q [2];
  logic [9:0]  map_addr;
  logic [10:0] tile_addr;
  logic [5:0]  pal_addr;
  logic        is_wr0, is_wr1, is_wr2;
  logic [15:0] entry;
  logic [2:0]  row;
  logic [3:0]  color;

  logic [15:0]   oq_r [tbc_pkg::OUT_DEPTH];
  logic [OW-1:0] owp_r, orp_r;
  logic [OW:0]   ocnt_r, ocnt_nxt;
  logic [1:0]    inflight;
  logic          credit_ok, opush, opop;
  logic [15:0]   result;

  // issue: a render only goes when the result queue has room for everything in flight
  always_comb begin
    inflight  = 2'(s1_r.valid && s1_r.ent.kind != tbc_pkg::K_WRITE) +
                2'(s2_r.valid && s2_r.ent.kind != tbc_pkg::K_WRITE) +
                2'(s3_r.valid && s3_r.ent.kind != tbc_pkg::K_WRITE);
    credit_ok = ({1'b0, ocnt_r} + (OW+2)'(inflight)) < (OW+2)'(tbc_pkg::OUT_DEPTH);
    head_pop  = head.valid && (head.ent.kind == tbc_pkg::K_WRITE || credit_ok);
  end

  // stage 0: tile map, writes land here so that order is kept per region
  assign is_wr0   = head_pop && head.ent.kind == tbc_pkg::K_WRITE &&
                    head.ent.addr[13:11] == 3'b100;
  assign map_addr = (head.ent.kind == tbc_pkg::K_WRITE) ? head.ent.addr[10:1] :
                    {head.ent.py[7:3], head.ent.px[7:3]};

  for (genvar b = 0; b < 2; b++) begin : g_map
    tbc_ram #(.WIDTH(8), .DEPTH(tbc_pkg::MAP_WORDS)) u_ram (
      .clk   (clk),
      .we    (is_wr0 && head.ent.addr[0] == 1'(b)),
      .addr  (map_addr),
      .wdata (head.ent.data),
      .rdata (map_q[b])
    );
  end

  // stage 1: tile planes, banked by plane pair and byte lane
  always_comb begin
    entry      = {map_q[1], map_q[0]};
    row        = entry[15] ? ~s1_r.ent.py[2:0] : s1_r.ent.py[2:0];
    s2_bit_nxt = entry[14] ? s1_r.ent.px[2:0] : ~s1_r.ent.px[2:0];
    s2_pal_nxt = entry[12] ? entry[11:10] : 2'd0;
    is_wr1     = s1_r.valid && s1_r.ent.kind == tbc_pkg::K_WRITE && !s1_r.ent.addr[13];
    tile_addr  = (s1_r.ent.kind == tbc_pkg::K_WRITE) ?
                 {s1_r.ent.addr[12:5], s1_r.ent.addr[3:1]} : {entry[7:0], row};
  end

  for (genvar b = 0; b < 4; b++) begin : g_tile
    tbc_ram #(.WIDTH(8), .DEPTH(tbc_pkg::TILE_WORDS)) u_ram (
      .clk   (clk),
      .we    (is_wr1 && {s1_r.ent.addr[4], s1_r.ent.addr[0]} == 2'(b)),
      .addr  (tile_addr),
      .wdata (s1_r.ent.data),
      .rdata (tile_q[b])
    );
  end

  // stage 2: palette lookup, colour 0 shares entry 0 of palette 0
  always_comb begin
    color    = {tile_q[3][s2_bit_r], tile_q[2][s2_bit_r],
                tile_q[1][s2_bit_r], tile_q[0][s2_bit_r]};
    is_wr2   = s2_r.valid && s2_r.ent.kind == tbc_pkg::K_WRITE &&
               s2_r.ent.addr[13:7] == tbc_pkg::PAL_REGION;
    if (s2_r.ent.kind == tbc_pkg::K_WRITE) begin
      pal_addr = s2_r.ent.addr[6:1];
    end else if (color != 4'd0) begin
      pal_addr = {s2_pal_r, color};
    end else begin
      pal_addr = 6'd0;
    end
  end

  for (genvar b = 0; b < 2; b++) begin : g_pal
    tbc_ram #(.WIDTH(8), .DEPTH(tbc_pkg::PAL_WORDS)) u_ram (
      .clk   (clk),
      .we    (is_wr2 && s2_r.ent.addr[0] == 1'(b)),
      .addr  (pal_addr),
      .wdata (s2_r.ent.data),
      .rdata (pal_q[b])
    );
  end

  // stage 3: pick the result
  always_comb begin
    result = (s3_r.ent.kind == tbc_pkg::K_DECODE) ? {1'b0, pal_q[1][6:0], pal_q[0]} :
             s3_r.ent.color;
    opush  = s3_r.valid && s3_r.ent.kind != tbc_pkg::K_WRITE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
    end else begin
      s1_r.valid <= head_pop;
      s2_r.valid <= s1_r.valid;
      s3_r.valid <= s2_r.valid;
    end
    s1_r.ent <= head.ent;
    s2_r.ent <= s1_r.ent;
    s3_r.ent <= s2_r.ent;
    s2_pal_r <= s2_pal_nxt;
    s2_bit_r <= s2_bit_nxt;
  end

  // result queue
  assign out_empty       = (ocnt_r == '0);
  assign out_pixel_color = oq_r[orp_r];
  assign opop            = out_pop && !out_empty;
  assign ocnt_nxt        = ocnt_r + (OW+1)'(opush) - (OW+1)'(opop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owp_r  <= opush ? owp_r + 1'b1 : owp_r;
      orp_r  <= opop ? orp_r + 1'b1 : orp_r;
      ocnt_r <= ocnt_nxt;
    end
    if (opush) begin
      oq_r[owp_r] <= result;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tile_border_compositor.sv]
// ----------------------------------------------------------------------------
// tile_border_compositor
// composites a game pixel stream into a tiled or banded border frame
// ----------------------------------------------------------------------------
// Items enter at one per clock while in_full is low and results leave at one
// per clock while out_pop finds one waiting. A render pixel waits in the front
// queue for credit, then passes the map, tile and palette ram stages. Byte
// writes travel the same pipeline into the store region of the stage that
// reads it, so every render sees exactly the writes pushed before it. The
// store is split into map, tile and palette rams, each read once per pixel.
`default_nettype none

module tile_border_compositor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_write_en,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_command,
  input  wire logic [13:0] in_load_address,
  input  wire logic [7:0]  in_load_data,
  input  wire logic [7:0]  in_pixel_x,
  input  wire logic [7:0]  in_pixel_y,
  input  wire logic [15:0] in_game_pixel,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [15:0]      out_pixel_color
);

  tbc_pkg::cfg_t   cfg_r, cfg_nxt;
  tbc_pkg::qhead_t head;
  logic            head_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write_en) begin
      unique case (cfg_index)
        tbc_pkg::CFG_DISPLAY_MODE:  cfg_nxt.display_mode  = cfg_data;
        tbc_pkg::CFG_BORDER_LOADED: cfg_nxt.border_loaded = cfg_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tbc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_command      (in_command),
    .in_load_address (in_load_address),
    .in_load_data    (in_load_data),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_game_pixel   (in_game_pixel),
    .head            (head),
    .head_pop        (head_pop)
  );

  tbc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_pop        (head_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pixel_color (out_pixel_color)
  );

endmodule

`default_nettype wire

[hw/rtl/tbc_checker.sv]
// ----------------------------------------------------------------------------
// tbc_checker
// port level checks of the tile border compositor
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tbc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_push,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [15:0] out_pixel_color
);

  // both queues come out of reset drained
  `TBC_ASSERT_RST(a_rst_empty, clk, !rst_n |=> out_empty, "result queue not empty after reset")
  `TBC_ASSERT_RST(a_rst_room, clk, !rst_n |=> !in_full, "input queue full after reset")

  // a waiting result holds until taken
  `TBC_ASSERT(a_hold, clk, rst_n, !out_empty && !out_pop |=> !out_empty && $stable(out_pixel_color), "result changed while stalled")

  // with no result waiting the back end always has room, so a full input queue drains
  `TBC_ASSERT(a_full_drain, clk, rst_n, in_full && out_empty |=> !in_full, "input queue stuck full")

endmodule

bind tile_border_compositor tbc_checker u_chk (.*);

`default_nettype wire
